// ----- src/lltk_pkg.sv -----
// Shared types, token kind codes and character helpers for the line lexer.
package lltk_pkg;

    localparam int MAX_LINE_DEF = 256;
    localparam int PREFIX_LEN   = 9;
    localparam int KW_COUNT     = 24;
    localparam int FIFO_DEPTH   = 8;

    localparam logic [5:0] K_END    = 6'd0;
    localparam logic [5:0] K_IDENT  = 6'd1;
    localparam logic [5:0] K_NUMBER = 6'd2;
    localparam logic [5:0] K_STRING = 6'd3;
    localparam logic [5:0] K_CHAR   = 6'd4;
    localparam logic [5:0] K_KW0    = 6'd5;
    localparam logic [5:0] K_EQEQ   = 6'd29;
    localparam logic [5:0] K_NE     = 6'd30;
    localparam logic [5:0] K_GE     = 6'd31;
    localparam logic [5:0] K_LE     = 6'd32;
    localparam logic [5:0] K_AND    = 6'd33;
    localparam logic [5:0] K_OR     = 6'd34;
    localparam logic [5:0] K_NOT    = 6'd35;
    localparam logic [5:0] K_EQ     = 6'd36;
    localparam logic [5:0] K_PLUS   = 6'd37;
    localparam logic [5:0] K_MINUS  = 6'd38;
    localparam logic [5:0] K_STAR   = 6'd39;
    localparam logic [5:0] K_SLASH  = 6'd40;
    localparam logic [5:0] K_MOD    = 6'd41;
    localparam logic [5:0] K_GT     = 6'd42;
    localparam logic [5:0] K_LT     = 6'd43;
    localparam logic [5:0] K_LBRACE = 6'd44;
    localparam logic [5:0] K_RBRACE = 6'd45;

    typedef logic [0:PREFIX_LEN-1][7:0] t_prefix;

    typedef struct packed {
        logic [5:0] kind;
        logic [7:0] start;
        logic [8:0] length;
        logic       run_end;
        logic       overflow;
    } t_token;

    typedef struct packed {
        logic [1:0]       count;
        t_token [2:0]     tok;
    } t_push;

    typedef struct packed {
        logic [71:0] text;
        logic [3:0]  len;
    } t_kw;

    function automatic logic f_is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic f_is_alpha(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic logic f_is_word(input logic [7:0] b);
        return f_is_alpha(b) || f_is_digit(b) || (b == "_");
    endfunction

    function automatic logic f_is_space(input logic [7:0] b);
        return (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

    // Keyword texts sit left-aligned, first character in the top byte.
    function automatic t_kw f_kw_entry(input int i);
        t_kw e;
        case (i)
            0:  e = '{72'("print"), 4'd5};
            1:  e = '{72'("take"), 4'd4};
            2:  e = '{72'("make"), 4'd4};
            3:  e = '{72'("set"), 4'd3};
            4:  e = '{72'("whole"), 4'd5};
            5:  e = '{72'("real"), 4'd4};
            6:  e = '{72'("symbol"), 4'd6};
            7:  e = '{72'("string"), 4'd6};
            8:  e = '{72'("bool"), 4'd4};
            9:  e = '{72'("true"), 4'd4};
            10: e = '{72'("false"), 4'd5};
            11: e = '{72'("if"), 4'd2};
            12: e = '{72'("then"), 4'd4};
            13: e = '{72'("else"), 4'd4};
            14: e = '{72'("elseif"), 4'd6};
            15: e = '{72'("endif"), 4'd5};
            16: e = '{72'("while"), 4'd5};
            17: e = '{72'("do"), 4'd2};
            18: e = '{72'("endwhile"), 4'd8};
            19: e = '{72'("repeat"), 4'd6};
            20: e = '{72'("times"), 4'd5};
            21: e = '{72'("endrepeat"), 4'd9};
            22: e = '{72'("break"), 4'd5};
            default: e = '{72'("continue"), 4'd8};
        endcase
        e.text = e.text << (8 * (PREFIX_LEN - int'(e.len)));
        return e;
    endfunction

    function automatic logic [5:0] f_word_kind(input t_prefix pre, input logic [8:0] len);
        logic [5:0] k;
        t_kw        e;
        k = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            e = f_kw_entry(i);
            if ((len == 9'(e.len)) && (pre == e.text)) begin
                k = K_KW0 + 6'(i);
            end
        end
        return k;
    endfunction

endpackage

// ----- src/line_lexer_token_stream_unit.sv -----
// Top level of the streaming line lexer: byte channel in, token channel out.
// One byte beat is taken per cycle while o_ready is high; each beat yields
// zero to three tokens (kind, start offset, length), the last flagged with
// run_end, and the beat marked last_in_line adds an END token and clears
// the line state. Tokens leave through an eight-entry queue at one per cycle
// while i_ready is high, and o_ready drops while the queue has fewer than
// three free entries, so the sustained rate is one byte per cycle unless the
// text averages over one token per byte, when the output port sets the pace.
module line_lexer_token_stream_unit
    import lltk_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_byte,
    input  logic       i_has_char,
    input  logic       i_last_in_line,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [5:0] o_token_kind,
    output logic [7:0] o_token_start,
    output logic [8:0] o_token_length,
    output logic       o_run_end,
    output logic       o_line_overflow
);

    t_push  w_push;
    t_token w_tok;
    logic   w_space;

    assign o_ready = w_space;

    lltk_lexer #(.MAX_LINE(MAX_LINE)) u_lexer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (i_valid && w_space),
        .i_char_byte    (i_char_byte),
        .i_has_char     (i_has_char),
        .i_last_in_line (i_last_in_line),
        .o_push         (w_push)
    );

    lltk_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (o_valid && i_ready),
        .o_space (w_space),
        .o_valid (o_valid),
        .o_tok   (w_tok)
    );

    assign o_token_kind    = w_tok.kind;
    assign o_token_start   = w_tok.start;
    assign o_token_length  = w_tok.length;
    assign o_run_end       = w_tok.run_end;
    assign o_line_overflow = w_tok.overflow;

endmodule

// ----- src/lltk_lexer.sv -----
// Lexer state machine: consumes one byte beat and produces up to three tokens.
module lltk_lexer
    import lltk_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char_byte,
    input  logic       i_has_char,
    input  logic       i_last_in_line,
    output t_push      o_push
);

    localparam int PW        = $clog2(MAX_LINE + 1);
    localparam int START_CAP = (MAX_LINE - 1 < 255) ? MAX_LINE - 1 : 255;
    localparam int LEN_CAP   = (MAX_LINE < 256) ? MAX_LINE : 256;

    typedef enum logic [3:0] {
        MODE_IDLE, MODE_STR, MODE_CHAR, MODE_CHAR_CLOSE, MODE_MINUS,
        MODE_INT, MODE_DOT, MODE_FRAC, MODE_WORD, MODE_OP
    } t_mode;

    t_mode         r_mode, n_mode;
    logic [7:0]    r_hop, n_hop;
    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_st, n_st;
    logic [8:0]    r_ln, n_ln;
    t_prefix       r_pre, n_pre;
    logic          r_ovf, n_ovf;

    function automatic logic [7:0] f_clamp(input logic [PW:0] v);
        return (v > (PW+1)'(START_CAP)) ? 8'(START_CAP) : v[7:0];
    endfunction

    function automatic logic [8:0] f_len_add(input logic [8:0] l, input logic [1:0] n);
        logic [9:0] v;
        v = {1'b0, l} + 10'(n);
        return (v > 10'(LEN_CAP)) ? 9'(LEN_CAP) : v[8:0];
    endfunction

    function automatic t_token f_tok(input logic [5:0] k, input logic [7:0] s,
                                     input logic [8:0] l, input logic ovf);
        t_token t;
        t.kind     = k;
        t.start    = s;
        t.length   = l;
        t.run_end  = 1'b0;
        t.overflow = ovf;
        return t;
    endfunction

    function automatic logic [5:0] f_single_op(input logic [7:0] h);
        logic [5:0] k;
        case (h)
            "=":     k = K_EQ;
            "!":     k = K_NOT;
            ">":     k = K_GT;
            "<":     k = K_LT;
            default: k = K_END;
        endcase
        return k;
    endfunction

    always_comb begin
        logic [7:0]    b;
        logic [PW-1:0] p;
        logic          go_idle;
        logic [1:0]    cnt;
        t_token [2:0]  res;
        logic [5:0]    sk;

        n_mode = r_mode;
        n_hop  = r_hop;
        n_pos  = r_pos;
        n_st   = r_st;
        n_ln   = r_ln;
        n_pre  = r_pre;
        n_ovf  = r_ovf;
        b       = i_char_byte;
        p       = r_pos;
        go_idle = 1'b0;
        cnt     = 2'd0;
        res     = '0;
        sk      = K_END;

        if (i_has_char) begin
            if (r_pos >= PW'(MAX_LINE)) begin
                n_ovf = 1'b1;
                p     = PW'(MAX_LINE);
            end else begin
                n_pos = r_pos + PW'(1);
            end

            case (r_mode)
                MODE_STR: begin
                    if (b == "\"") begin
                        res[cnt] = f_tok(K_STRING, r_st, r_ln, n_ovf);
                        cnt = cnt + 2'd1;
                        n_mode = MODE_IDLE;
                    end else begin
                        n_ln = f_len_add(r_ln, 2'd1);
                    end
                end
                MODE_CHAR: begin
                    res[cnt] = f_tok(K_CHAR, f_clamp({1'b0, p}), 9'd1, n_ovf);
                    cnt = cnt + 2'd1;
                    n_mode = MODE_CHAR_CLOSE;
                end
                MODE_CHAR_CLOSE: begin
                    if (b == "'") n_mode = MODE_IDLE;
                    else go_idle = 1'b1;
                end
                MODE_MINUS: begin
                    if (f_is_digit(b)) begin
                        n_mode = MODE_INT;
                        n_ln = f_len_add(r_ln, 2'd1);
                    end else begin
                        res[cnt] = f_tok(K_MINUS, r_st, 9'd1, n_ovf);
                        cnt = cnt + 2'd1;
                        go_idle = 1'b1;
                    end
                end
                MODE_INT: begin
                    if (f_is_digit(b)) begin
                        n_ln = f_len_add(r_ln, 2'd1);
                    end else if (b == ".") begin
                        n_mode = MODE_DOT;
                    end else begin
                        res[cnt] = f_tok(K_NUMBER, r_st, r_ln, n_ovf);
                        cnt = cnt + 2'd1;
                        go_idle = 1'b1;
                    end
                end
                MODE_DOT: begin
                    // The dot only counts once a digit follows it.
                    if (f_is_digit(b)) begin
                        n_mode = MODE_FRAC;
                        n_ln = f_len_add(r_ln, 2'd2);
                    end else begin
                        res[cnt] = f_tok(K_NUMBER, r_st, r_ln, n_ovf);
                        cnt = cnt + 2'd1;
                        go_idle = 1'b1;
                    end
                end
                MODE_FRAC: begin
                    if (f_is_digit(b)) begin
                        n_ln = f_len_add(r_ln, 2'd1);
                    end else begin
                        res[cnt] = f_tok(K_NUMBER, r_st, r_ln, n_ovf);
                        cnt = cnt + 2'd1;
                        go_idle = 1'b1;
                    end
                end
                MODE_WORD: begin
                    if (f_is_word(b)) begin
                        if (r_ln < 9'(PREFIX_LEN)) n_pre[r_ln[3:0]] = b;
                        n_ln = f_len_add(r_ln, 2'd1);
                    end else begin
                        res[cnt] = f_tok(f_word_kind(r_pre, r_ln), r_st, r_ln, n_ovf);
                        cnt = cnt + 2'd1;
                        go_idle = 1'b1;
                    end
                end
                MODE_OP: begin
                    if (b == "=" && r_hop == "=") sk = K_EQEQ;
                    else if (b == "=" && r_hop == "!") sk = K_NE;
                    else if (b == "=" && r_hop == ">") sk = K_GE;
                    else if (b == "=" && r_hop == "<") sk = K_LE;
                    else if (b == "&" && r_hop == "&") sk = K_AND;
                    else if (b == "|" && r_hop == "|") sk = K_OR;
                    if (sk != K_END) begin
                        res[cnt] = f_tok(sk, r_st, 9'd2, n_ovf);
                        cnt = cnt + 2'd1;
                        n_mode = MODE_IDLE;
                    end else begin
                        if (f_single_op(r_hop) != K_END) begin
                            res[cnt] = f_tok(f_single_op(r_hop), r_st, 9'd1, n_ovf);
                            cnt = cnt + 2'd1;
                        end
                        go_idle = 1'b1;
                    end
                end
                default: go_idle = 1'b1;
            endcase

            if (go_idle) begin
                n_mode = MODE_IDLE;
                if (f_is_space(b)) begin
                    n_mode = MODE_IDLE;
                end else if (b == "\"") begin
                    n_mode = MODE_STR;
                    n_st = f_clamp({1'b0, p} + (PW+1)'(1));
                    n_ln = 9'd0;
                end else if (b == "'") begin
                    n_mode = MODE_CHAR;
                    n_st = f_clamp({1'b0, p} + (PW+1)'(1));
                    n_ln = 9'd0;
                end else if (f_is_digit(b) || b == "-") begin
                    n_mode = f_is_digit(b) ? MODE_INT : MODE_MINUS;
                    n_st = f_clamp({1'b0, p});
                    n_ln = 9'd1;
                end else if (f_is_alpha(b) || b == "_") begin
                    n_mode = MODE_WORD;
                    n_st = f_clamp({1'b0, p});
                    n_ln = 9'd1;
                    n_pre = '0;
                    n_pre[0] = b;
                end else begin
                    case (b)
                        "=", "!", ">", "<", "&", "|": begin
                            n_mode = MODE_OP;
                            n_st = f_clamp({1'b0, p});
                            n_ln = 9'd1;
                            n_hop = b;
                        end
                        "+": sk = K_PLUS;
                        "*": sk = K_STAR;
                        "/": sk = K_SLASH;
                        "%": sk = K_MOD;
                        "{": sk = K_LBRACE;
                        "}": sk = K_RBRACE;
                        default: sk = K_END;
                    endcase
                    if (n_mode == MODE_IDLE && sk != K_END) begin
                        res[cnt] = f_tok(sk, f_clamp({1'b0, p}), 9'd1, n_ovf);
                        cnt = cnt + 2'd1;
                    end
                end
            end
        end

        if (i_last_in_line) begin
            case (n_mode)
                MODE_STR: begin
                    res[cnt] = f_tok(K_STRING, n_st, n_ln, n_ovf);
                    cnt = cnt + 2'd1;
                end
                MODE_CHAR: begin
                    // A quote closing the line gives an empty char just past it.
                    res[cnt] = f_tok(K_CHAR, f_clamp({1'b0, n_pos}), 9'd0, n_ovf);
                    cnt = cnt + 2'd1;
                end
                MODE_MINUS: begin
                    res[cnt] = f_tok(K_MINUS, n_st, 9'd1, n_ovf);
                    cnt = cnt + 2'd1;
                end
                MODE_INT, MODE_DOT, MODE_FRAC: begin
                    res[cnt] = f_tok(K_NUMBER, n_st, n_ln, n_ovf);
                    cnt = cnt + 2'd1;
                end
                MODE_WORD: begin
                    res[cnt] = f_tok(f_word_kind(n_pre, n_ln), n_st, n_ln, n_ovf);
                    cnt = cnt + 2'd1;
                end
                MODE_OP: begin
                    if (f_single_op(n_hop) != K_END) begin
                        res[cnt] = f_tok(f_single_op(n_hop), n_st, 9'd1, n_ovf);
                        cnt = cnt + 2'd1;
                    end
                end
                default: ;
            endcase
            res[cnt] = f_tok(K_END, 8'd0, 9'd0, n_ovf);
            cnt = cnt + 2'd1;
            n_mode = MODE_IDLE;
            n_hop  = '0;
            n_pos  = '0;
            n_st   = '0;
            n_ln   = '0;
            n_pre  = '0;
            n_ovf  = 1'b0;
        end

        for (int i = 0; i < 3; i++) begin
            res[i].run_end = (2'(i + 1) == cnt);
        end
        o_push.count = i_accept ? cnt : 2'd0;
        o_push.tok   = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_hop  <= '0;
            r_pos  <= '0;
            r_st   <= '0;
            r_ln   <= '0;
            r_pre  <= '0;
            r_ovf  <= 1'b0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_hop  <= n_hop;
            r_pos  <= n_pos;
            r_st   <= n_st;
            r_ln   <= n_ln;
            r_pre  <= n_pre;
            r_ovf  <= n_ovf;
        end
    end

endmodule

// ----- src/lltk_result_fifo.sv -----
// Token queue that takes up to three tokens a cycle and hands out one.
module lltk_result_fifo
    import lltk_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output logic   o_space,
    output logic   o_valid,
    output t_token o_tok
);

    localparam int AW = $clog2(FIFO_DEPTH);

    t_token        r_mem [FIFO_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rp];
    // Room for the largest burst one beat can cause.
    assign o_space = (r_cnt <= (AW+1)'(FIFO_DEPTH - 3));

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < i_push.count) r_mem[r_wp + AW'(i)] <= i_push.tok[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + AW'(i_push.count);
            r_rp  <= r_rp + AW'(i_pop);
            r_cnt <= r_cnt + (AW+1)'(i_push.count) - (AW+1)'(i_pop);
        end
    end

endmodule

// ----- tb/sv/tb_line_lexer_token_stream_unit.sv -----
// Testbench for the streaming line lexer: predicts tokens per byte beat and checks the output stream.
`timescale 1ns / 1ps

module tb_line_lexer_token_stream_unit;
    import lltk_pkg::*;

    localparam int LINE_CAP = 256;

    typedef enum logic [3:0] {
        LM_IDLE, LM_STR, LM_CHAR, LM_CHAR_CLOSE, LM_MINUS,
        LM_INT, LM_DOT, LM_FRAC, LM_WORD, LM_OP
    } t_lex_mode;

    typedef struct packed {
        logic [7:0] chr;
        logic       has;
        logic       last;
    } t_byte_beat;

    typedef struct packed {
        logic [5:0] kind;
        logic [7:0] start;
        logic [8:0] length;
        logic       run_end;
        logic       overflow;
    } t_tok;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_char_byte;
    logic       i_has_char;
    logic       i_last_in_line;
    logic       o_valid;
    logic       i_ready;
    logic [5:0] o_token_kind;
    logic [7:0] o_token_start;
    logic [8:0] o_token_length;
    logic       o_run_end;
    logic       o_line_overflow;

    line_lexer_token_stream_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_char_byte    (i_char_byte),
        .i_has_char     (i_has_char),
        .i_last_in_line (i_last_in_line),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_run_end      (o_run_end),
        .o_line_overflow(o_line_overflow)
    );

    t_byte_beat pending_beats[$];
    t_tok       expected_tokens[$];
    int         fail_count = 0;
    bit         stim_done = 0;
    int         idle_pct = 36;
    int         hold_off = 0;

    // Predictor state for the line being lexed.
    t_lex_mode  lx_mode;
    logic [7:0] lx_held;
    int         lx_pos;
    int         lx_start;
    int         lx_len;
    logic [7:0] lx_word[9];
    bit         lx_ovf;
    t_tok       step_toks[$];

    string kw_names[24] = '{"print", "take", "make", "set", "whole", "real", "symbol",
        "string", "bool", "true", "false", "if", "then", "else", "elseif", "endif",
        "while", "do", "endwhile", "repeat", "times", "endrepeat", "break", "continue"};

    function automatic bit is_dig(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_alp(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_sp(logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic int sat_start(int p);
        return p > 255 ? 255 : p;
    endfunction

    function void clear_line();
        lx_mode = LM_IDLE;
        lx_held = 0;
        lx_pos = 0;
        lx_start = 0;
        lx_len = 0;
        foreach (lx_word[i]) lx_word[i] = 0;
        lx_ovf = 0;
    endfunction

    function void push_tok(logic [5:0] k, int s, int l);
        t_tok t;
        if (step_toks.size() >= 3) return;
        t.kind = k;
        t.start = 8'(sat_start(s));
        t.length = 9'(l > 256 ? 256 : l);
        t.run_end = 0;
        t.overflow = lx_ovf;
        step_toks.push_back(t);
    endfunction

    function void grow_len(int n);
        lx_len = lx_len + n > 256 ? 256 : lx_len + n;
    endfunction

    function void open_tok(t_lex_mode m, int s, int l);
        lx_mode = m;
        lx_start = sat_start(s);
        lx_len = 0;
        grow_len(l);
    endfunction

    function void word_tok();
        logic [5:0] k;
        bit hit;
        k = K_IDENT;
        if (lx_len <= 9) begin
            for (int i = 0; i < 24; i++) begin
                if (kw_names[i].len() == lx_len) begin
                    hit = 1;
                    for (int j = 0; j < lx_len; j++)
                        if (lx_word[j] != kw_names[i][j]) hit = 0;
                    if (hit && k == K_IDENT) k = K_KW0 + 6'(i);
                end
            end
        end
        push_tok(k, lx_start, lx_len);
    endfunction

    function void lone_op();
        case (lx_held)
            "=": push_tok(K_EQ, lx_start, 1);
            "!": push_tok(K_NOT, lx_start, 1);
            ">": push_tok(K_GT, lx_start, 1);
            "<": push_tok(K_LT, lx_start, 1);
            default: ;
        endcase
    endfunction

    function void lex_fresh(logic [7:0] b, int p);
        lx_mode = LM_IDLE;
        if (is_sp(b)) return;
        if (b == "\"") open_tok(LM_STR, p + 1, 0);
        else if (b == "'") open_tok(LM_CHAR, p + 1, 0);
        else if (is_dig(b)) open_tok(LM_INT, p, 1);
        else if (b == "-") open_tok(LM_MINUS, p, 1);
        else if (is_alp(b) || b == "_") begin
            open_tok(LM_WORD, p, 1);
            foreach (lx_word[i]) lx_word[i] = 0;
            lx_word[0] = b;
        end else begin
            case (b)
                "=", "!", ">", "<", "&", "|": begin
                    open_tok(LM_OP, p, 1);
                    lx_held = b;
                end
                "+": push_tok(K_PLUS, p, 1);
                "*": push_tok(K_STAR, p, 1);
                "/": push_tok(K_SLASH, p, 1);
                "%": push_tok(K_MOD, p, 1);
                "{": push_tok(K_LBRACE, p, 1);
                "}": push_tok(K_RBRACE, p, 1);
                default: ;
            endcase
        end
    endfunction

    // Returns 1 when the byte was consumed by the open token.
    function bit lex_open(logic [7:0] b, int p);
        case (lx_mode)
            LM_STR: begin
                if (b == "\"") begin
                    push_tok(K_STRING, lx_start, lx_len);
                    lx_mode = LM_IDLE;
                end else grow_len(1);
                return 1;
            end
            LM_CHAR: begin
                push_tok(K_CHAR, p, 1);
                lx_mode = LM_CHAR_CLOSE;
                return 1;
            end
            LM_CHAR_CLOSE: begin
                if (b == "'") begin
                    lx_mode = LM_IDLE;
                    return 1;
                end
            end
            LM_MINUS: begin
                if (is_dig(b)) begin
                    lx_mode = LM_INT;
                    grow_len(1);
                    return 1;
                end
                push_tok(K_MINUS, lx_start, 1);
            end
            LM_INT: begin
                if (is_dig(b)) begin
                    grow_len(1);
                    return 1;
                end
                if (b == ".") begin
                    lx_mode = LM_DOT;
                    return 1;
                end
                push_tok(K_NUMBER, lx_start, lx_len);
            end
            LM_DOT: begin
                if (is_dig(b)) begin
                    lx_mode = LM_FRAC;
                    grow_len(2);
                    return 1;
                end
                push_tok(K_NUMBER, lx_start, lx_len);
            end
            LM_FRAC: begin
                if (is_dig(b)) begin
                    grow_len(1);
                    return 1;
                end
                push_tok(K_NUMBER, lx_start, lx_len);
            end
            LM_WORD: begin
                if (is_alp(b) || is_dig(b) || b == "_") begin
                    if (lx_len < 9) lx_word[lx_len] = b;
                    grow_len(1);
                    return 1;
                end
                word_tok();
            end
            LM_OP: begin
                if (b == "=" && lx_held == "=") push_tok(K_EQEQ, lx_start, 2);
                else if (b == "=" && lx_held == "!") push_tok(K_NE, lx_start, 2);
                else if (b == "=" && lx_held == ">") push_tok(K_GE, lx_start, 2);
                else if (b == "=" && lx_held == "<") push_tok(K_LE, lx_start, 2);
                else if (b == "&" && lx_held == "&") push_tok(K_AND, lx_start, 2);
                else if (b == "|" && lx_held == "|") push_tok(K_OR, lx_start, 2);
                else begin
                    lone_op();
                    return 0;
                end
                lx_mode = LM_IDLE;
                return 1;
            end
            default: ;
        endcase
        return 0;
    endfunction

    function void predict_tokens(t_byte_beat bt);
        int p;
        step_toks.delete();
        if (bt.has) begin
            p = lx_pos;
            if (p >= LINE_CAP) begin
                lx_ovf = 1;
                p = LINE_CAP;
            end else lx_pos = p + 1;
            if (!lex_open(bt.chr, p)) lex_fresh(bt.chr, p);
        end
        if (bt.last) begin
            case (lx_mode)
                LM_STR: push_tok(K_STRING, lx_start, lx_len);
                LM_CHAR: push_tok(K_CHAR, lx_pos, 0);
                LM_MINUS: push_tok(K_MINUS, lx_start, 1);
                LM_INT, LM_DOT, LM_FRAC: push_tok(K_NUMBER, lx_start, lx_len);
                LM_WORD: word_tok();
                LM_OP: lone_op();
                default: ;
            endcase
            push_tok(K_END, 0, 0);
            clear_line();
        end
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].run_end = 1;
        foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
    endfunction

    task automatic add_text(string s, bit end_line);
        t_byte_beat bt;
        for (int i = 0; i < s.len(); i++) begin
            bt.chr = s[i];
            bt.has = 1;
            bt.last = end_line && (i == s.len() - 1);
            pending_beats.push_back(bt);
        end
    endtask

    task automatic add_beat(logic [7:0] c, bit has, bit last);
        t_byte_beat bt;
        bt.chr = c;
        bt.has = has;
        bt.last = last;
        pending_beats.push_back(bt);
    endtask

    function automatic string rand_piece();
        string s;
        string wchars;
        int n;
        s = "";
        wchars = "_0aZ";
        case ($urandom_range(0, 11))
            0: s = kw_names[$urandom_range(0, 23)];
            1: begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    s = {s, string'(i == 0 ? "a" + 8'($urandom_range(0, 25)) :
                        wchars[$urandom_range(0, 3)])};
            end
            2: begin
                if ($urandom_range(0, 1)) s = "-";
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) s = {s, string'("0" + 8'($urandom_range(0, 9)))};
                if ($urandom_range(0, 1)) begin
                    s = {s, "."};
                    n = $urandom_range(0, 2);
                    for (int i = 0; i < n; i++) s = {s, "7"};
                end
            end
            3: begin
                s = "\"";
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(1, 255)))};
                if (s.len() > 1 && s[s.len() - 1] == "\"") s = {s, "x"};
                s = {s, "\""};
            end
            4: s = {"'", string'(8'($urandom_range(1, 255))), "'"};
            5: begin
                string ops[17] = '{"==", "!=", ">=", "<=", "&&", "||", "!", "=", "+", "-",
                    "*", "/", "%", ">", "<", "{", "}"};
                s = ops[$urandom_range(0, 16)];
            end
            6: s = string'(8'($urandom_range(1, 255)));
            7: s = "&";
            8: s = "|";
            default: s = " ";
        endcase
        return s;
    endfunction

    always #5 i_clk = ~i_clk;

    // Driver: offers the oldest pending beat, idling at random between beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                predict_tokens({i_char_byte, i_has_char, i_last_in_line});
                void'(pending_beats.pop_front());
            end
            if (pending_beats.size() > (i_valid ? 1 : 0) - (i_valid ? 1 : 0) &&
                pending_beats.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                i_valid <= 1;
                i_char_byte <= pending_beats[0].chr;
                i_has_char <= pending_beats[0].has;
                i_last_in_line <= pending_beats[0].last;
            end else begin
                i_valid <= 0;
                if (pending_beats.size() == 0) stim_done <= 1;
            end
        end
    end

    // Monitor: checks each accepted token beat and drives the receiver's stalls.
    always @(posedge i_clk) begin
        t_tok want;
        if (!i_rst_n) begin
            i_ready <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("token_kind: unexpected token, actual %0d", o_token_kind);
                    fail_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (o_token_kind !== want.kind) begin
                        $error("token_kind: expected %0d actual %0d", want.kind, o_token_kind);
                        fail_count++;
                    end
                    if (o_token_start !== want.start) begin
                        $error("token_start: expected %0d actual %0d", want.start,
                            o_token_start);
                        fail_count++;
                    end
                    if (o_token_length !== want.length) begin
                        $error("token_length: expected %0d actual %0d", want.length,
                            o_token_length);
                        fail_count++;
                    end
                    if (o_run_end !== want.run_end) begin
                        $error("run_end: expected %0d actual %0d", want.run_end, o_run_end);
                        fail_count++;
                    end
                    if (o_line_overflow !== want.overflow) begin
                        $error("line_overflow: expected %0d actual %0d", want.overflow,
                            o_line_overflow);
                        fail_count++;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_ready <= 0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    initial begin
        i_clk = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_ready = 0;
        i_char_byte = 0;
        i_has_char = 0;
        i_last_in_line = 0;
        clear_line();

        // Directed lines covering each token form and the edge cases.
        add_text("print x_1 = -12.5 + 3. - a;", 1);
        add_text("if a>=b && c||d != e <= f == g then { } * / % ! < > & | endrepeat", 1);
        add_text("\"str\xff\x00 'q' \"open", 1);
        add_beat(8'h00, 1, 0);
        add_beat(8'hff, 1, 0);
        add_text("'", 1);
        add_beat(8'h00, 0, 1);
        add_beat(8'hff, 0, 0);
        add_text("continuex endwhile9 -x 7.", 1);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;

        // Long receiver hold-off while the sender keeps offering beats.
        hold_off = 60;

        while (pending_beats.size() > 0) @(posedge i_clk);

        // A line past the length limit so the positions saturate, sent with no idling.
        idle_pct = 0;
        for (int i = 0; i < 262; i++)
            add_beat(i % 50 == 0 ? " " : "a", 1, 0);
        add_text("\"zz", 1);
        while (pending_beats.size() > 0) @(posedge i_clk);

        idle_pct = 36;
        for (int n = 0; n < 30; ) begin
            string ln;
            ln = "";
            while (ln.len() < $urandom_range(4, 30)) begin
                ln = {ln, rand_piece()};
                if ($urandom_range(0, 2) == 0) ln = {ln, " "};
            end
            if ($urandom_range(0, 9) == 0) add_beat(8'($urandom()), 0, 0);
            add_text(ln, 1);
            n += ln.len();
        end
        wait (stim_done && pending_beats.size() == 0 && !i_valid);
        while (expected_tokens.size() > 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
